// ===== hw/rtl/label_argument_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// Label argument extractor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LABEL_ARGUMENT_EXTRACTOR_ASSERT_SVH
`define LABEL_ARGUMENT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication
`define LAE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LAE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lae_pkg.sv =====
// ----------------------------------------------------------------------------
// Label argument extractor package
// Shared types and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

	typedef logic [7:0] byte_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LABEL_TEXT      = 3'd0,
		REG_LABEL_LENGTH    = 3'd1,
		REG_DELIMITER_SET   = 3'd2,
		REG_DELIMITER_COUNT = 3'd3,
		REG_ARG_INDEX       = 3'd4
	} reg_idx_t;

	// Configuration register file contents
	typedef struct packed {
		logic [63:0] label_text;
		logic [3:0]  label_length;
		logic [63:0] delimiter_set;
		logic [3:0]  delimiter_count;
		logic [7:0]  arg_index;
	} cfg_t;

	// Status from the window matcher
	typedef struct packed {
		logic hit;        // label found at the window head
		logic before_ok;  // label starts the line or follows a delimiter
		logic cur_delim;  // newest character is a delimiter
	} match_t;

	// One result item
	typedef struct packed {
		byte_t arg_char;
		logic  arg_done;
		logic  found;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lae_if.sv =====
// ----------------------------------------------------------------------------
// Label argument extractor channels
// Character input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lae_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       line_end;

	modport source (output valid, output in_char, output line_end, input ready);
	modport sink   (input valid, input in_char, input line_end, output ready);
endinterface

interface lae_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] arg_char;
	logic       arg_done;
	logic       found;

	modport source (output valid, output arg_char, output arg_done, output found,
		input ready);
	modport sink   (input valid, input arg_char, input arg_done, input found,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lae_match.sv =====
// ----------------------------------------------------------------------------
// Label argument extractor window matcher
// Compares the character window against the label for every length in
// parallel and tests characters against the delimiter set.
// ----------------------------------------------------------------------------
`default_nettype none

module lae_match import lae_pkg::*; #(
	parameter int LABEL_MAX = 8,
	parameter int DELIM_MAX = 8,
	localparam int WIN      = LABEL_MAX + 1,
	localparam int CNT_W    = $clog2(WIN + 1),
	localparam int IDX_W    = (WIN > 1) ? $clog2(WIN) : 1
) (
	input  var byte_t            win [WIN],
	input  var logic [CNT_W-1:0] chars_seen,
	input  var cfg_t             cfg,
	output var match_t           status
);

	logic [CNT_W-1:0] len_eff;
	logic [3:0]       dcnt_eff;
	logic [WIN-1:0]   len_match;

	// Test one character against the valid delimiter bytes
	function automatic logic is_delim(byte_t c, logic [63:0] set, logic [3:0] cnt);
		logic r;
		r = 1'b0;
		for (int i = 0; i < DELIM_MAX; i++) begin
			if ((32'(cnt) > i) && (set[8*i +: 8] == c)) begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

	// Clamp label length and delimiter count into range
	always_comb begin
		if (cfg.label_length == 4'd0) begin
			len_eff = CNT_W'(1);
		end else if (32'(cfg.label_length) > LABEL_MAX) begin
			len_eff = CNT_W'(LABEL_MAX);
		end else begin
			len_eff = cfg.label_length[CNT_W-1:0];
		end
		if (32'(cfg.delimiter_count) > DELIM_MAX) begin
			dcnt_eff = 4'(DELIM_MAX);
		end else begin
			dcnt_eff = cfg.delimiter_count;
		end
	end

	// Compare window against label, one candidate per length
	always_comb begin
		len_match[0] = 1'b0;
		for (int l = 1; l < WIN; l++) begin
			len_match[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (win[l-1-k] != cfg.label_text[8*k +: 8]) begin
					len_match[l] = 1'b0;
				end
			end
		end
	end

	// Combine into status
	always_comb begin
		status.hit       = (chars_seen >= len_eff) && len_match[len_eff[IDX_W-1:0]];
		status.before_ok = (chars_seen == len_eff) ||
			is_delim(win[len_eff[IDX_W-1:0]], cfg.delimiter_set, dcnt_eff);
		status.cur_delim = is_delim(win[0], cfg.delimiter_set, dcnt_eff);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/label_argument_extractor.sv =====
// ----------------------------------------------------------------------------
// Label argument extractor
// Finds a configured label in a text line and emits the selected argument.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                     | transaction
//  ---------+-----+-----------------------------+---------------------------
//  line     | in  | in_char[7:0], line_end      | one character or line end
//  result   | out | arg_char[7:0], arg_done, fd | argument char or final flag
//  cfg      | in  | cfg_we, cfg_index, cfg_data | register write, no wait
//
//  One character per cycle while line is ready: window compare and delimiter
//  tests are parallel logic between the state registers and the result
//  register. Results are registered, via the skid entry when output waits.
//  A two-entry output stage (result register plus skid) keeps line ready
//  while one result waits; line stalls only when both entries are full.
//  Reset clears the line state and loads register reset values; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module label_argument_extractor import lae_pkg::*; #(
	parameter int LABEL_MAX = 8,
	parameter int DELIM_MAX = 8
) (
	input  var logic        clk,
	input  var logic        arst_n,
	lae_char_if.sink        line,
	lae_res_if.source       result,
	input  var logic        cfg_we,
	input  var logic [2:0]  cfg_index,
	input  var logic [63:0] cfg_data
);

`include "label_argument_extractor_assert.svh"

	localparam int WIN   = LABEL_MAX + 1;
	localparam int CNT_W = $clog2(WIN + 1);

	typedef enum logic [2:0] {
		PH_SEARCH, PH_CHECK_END, PH_COUNT, PH_COPY, PH_COPIED, PH_FAILED
	} phase_t;

	cfg_t             cfg_q;
	byte_t            win_q [WIN];
	byte_t            win_new [WIN];
	phase_t           phase_q, phase_d;
	logic [7:0]       dseen_q, dseen_d;
	logic [CNT_W-1:0] chars_seen_q, chars_new;
	logic             arg_nonempty_q, arg_nonempty_d;
	match_t           status;

	logic             line_fire;
	logic             res_gen;
	res_t             res_new;
	logic             out_valid_q, skid_valid_q;
	res_t             out_q, skid_q;
	logic             out_free;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.label_text      <= '0;
			cfg_q.label_length    <= 4'd1;
			cfg_q.delimiter_set   <= '0;
			cfg_q.delimiter_count <= 4'd1;
			cfg_q.arg_index       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LABEL_TEXT:      cfg_q.label_text      <= cfg_data;
				REG_LABEL_LENGTH:    cfg_q.label_length    <= cfg_data[3:0];
				REG_DELIMITER_SET:   cfg_q.delimiter_set   <= cfg_data;
				REG_DELIMITER_COUNT: cfg_q.delimiter_count <= cfg_data[3:0];
				REG_ARG_INDEX:       cfg_q.arg_index       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Shift the new character into the window and count characters
	always_comb begin
		win_new[0] = line.in_char;
		for (int j = 1; j < WIN; j++) begin
			win_new[j] = win_q[j-1];
		end
		if (32'(chars_seen_q) < WIN) begin
			chars_new = chars_seen_q + CNT_W'(1);
		end else begin
			chars_new = chars_seen_q;
		end
	end

	lae_match #(
		.LABEL_MAX (LABEL_MAX),
		.DELIM_MAX (DELIM_MAX)
	) u_match (
		.win        (win_new),
		.chars_seen (chars_new),
		.cfg        (cfg_q),
		.status     (status)
	);

	// Advance the line phase and build a result
	always_comb begin
		phase_d        = phase_q;
		dseen_d        = dseen_q;
		arg_nonempty_d = arg_nonempty_q;
		res_gen        = 1'b0;
		res_new        = '0;
		if (line.line_end) begin
			res_gen          = 1'b1;
			res_new.arg_done = 1'b1;
			res_new.found    = arg_nonempty_q;
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (status.hit) begin
						if (!status.before_ok) begin
							phase_d = PH_FAILED;
						end else if (status.cur_delim) begin
							if (cfg_q.arg_index == 8'd0) begin
								phase_d = PH_COPY;
							end else begin
								dseen_d = 8'd1;
								phase_d = PH_COUNT;
							end
						end else begin
							phase_d = PH_CHECK_END;
						end
					end
				end
				PH_CHECK_END: begin
					if (!status.cur_delim) begin
						phase_d = PH_FAILED;
					end else if (cfg_q.arg_index == 8'd0) begin
						phase_d = PH_COPY;
					end else begin
						dseen_d = 8'd1;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					if (status.cur_delim) begin
						if (dseen_q == cfg_q.arg_index) begin
							phase_d = PH_COPY;
						end else begin
							dseen_d = dseen_q + 8'd1;
						end
					end
				end
				PH_COPY: begin
					if (status.cur_delim) begin
						phase_d = PH_COPIED;
					end else begin
						arg_nonempty_d   = 1'b1;
						res_gen          = 1'b1;
						res_new.arg_char = line.in_char;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold line state; clear it at line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SEARCH;
			dseen_q        <= '0;
			chars_seen_q   <= '0;
			arg_nonempty_q <= 1'b0;
			for (int j = 0; j < WIN; j++) begin
				win_q[j] <= '0;
			end
		end else if (line_fire) begin
			if (line.line_end) begin
				phase_q        <= PH_SEARCH;
				dseen_q        <= '0;
				chars_seen_q   <= '0;
				arg_nonempty_q <= 1'b0;
				for (int j = 0; j < WIN; j++) begin
					win_q[j] <= '0;
				end
			end else begin
				phase_q        <= phase_d;
				dseen_q        <= dseen_d;
				chars_seen_q   <= chars_new;
				arg_nonempty_q <= arg_nonempty_d;
				for (int j = 0; j < WIN; j++) begin
					win_q[j] <= win_new[j];
				end
			end
		end
	end

	// Accept input while the skid entry is free
	assign line.ready = !skid_valid_q;
	assign line_fire  = line.valid && line.ready;
	assign out_free   = !out_valid_q || result.ready;

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || (line_fire && res_gen);
			skid_valid_q <= 1'b0;
		end else if (line_fire && res_gen) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payload alongside the valid bits
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (line_fire && res_gen) begin
			skid_q <= res_new;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.arg_char = out_q.arg_char;
	assign result.arg_done = out_q.arg_done;
	assign result.found    = out_q.found;

	// Skid entry fills only behind a waiting result
	`LAE_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
	// Line end returns the line state to its start
	`LAE_ASSERT_NXT(a_line_clear, line_fire && line.line_end,
		phase_q == PH_SEARCH && chars_seen_q == '0 && !arg_nonempty_q, "line state not cleared")
	// An emitted argument character means the copy phase was reached
	`LAE_ASSERT_IMP(a_nonempty_phase, arg_nonempty_q,
		phase_q == PH_COPY || phase_q == PH_COPIED, "argument flag outside copy")
	// Character count saturates at the window depth
	`LAE_ASSERT_IMP(a_count_sat, 1'b1, 32'(chars_seen_q) <= WIN, "character count overflow")

endmodule

`default_nettype wire

// ===== tb/lae_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Label argument extractor scoreboard
// Holds a cycle-free model of the extractor: it notes each accepted character
// or line end, works out the argument characters and final flag that the
// line should give, and checks each returned result against the oldest one.
// ----------------------------------------------------------------------------
package lae_tb_pkg;
	import lae_pkg::*;

	typedef enum logic [2:0] {
		SEEK_LABEL,
		CHECK_WORD_END,
		COUNT_DELIMS,
		COPY_ARG,
		ARG_DONE,
		LINE_FAILED
	} scan_phase_t;

	class arg_scoreboard;
		// register copies
		logic [63:0] label_text;
		logic [3:0]  label_length;
		logic [63:0] delimiter_set;
		logic [3:0]  delimiter_count;
		logic [7:0]  arg_index;

		// line state
		byte_t       recent [9];
		scan_phase_t phase;
		logic [7:0]  delims_seen;
		logic [3:0]  chars_seen;
		bit          arg_nonempty;

		res_t        expected_args [$];
		int          fails;

		function new();
			label_text      = '0;
			label_length    = 4'd1;
			delimiter_set   = '0;
			delimiter_count = 4'd1;
			arg_index       = '0;
			fails           = 0;
			clear_line();
		endfunction

		function void clear_line();
			foreach (recent[k]) recent[k] = '0;
			phase        = SEEK_LABEL;
			delims_seen  = '0;
			chars_seen   = '0;
			arg_nonempty = 1'b0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [63:0] value);
			case (idx)
				REG_LABEL_TEXT:      label_text      = value;
				REG_LABEL_LENGTH:    label_length    = value[3:0];
				REG_DELIMITER_SET:   delimiter_set   = value;
				REG_DELIMITER_COUNT: delimiter_count = value[3:0];
				REG_ARG_INDEX:       arg_index       = value[7:0];
				default: ;
			endcase
		endfunction

		function bit is_delim(byte_t c);
			int n = int'(delimiter_count);
			if (n > 8) n = 8;
			for (int i = 0; i < n; i++)
				if (delimiter_set[8*i +: 8] == c) return 1'b1;
			return 1'b0;
		endfunction

		// The anchor counts as delimiter one
		function void take_anchor();
			if (arg_index == 8'd0) begin
				phase = COPY_ARG;
			end else begin
				delims_seen = 8'd1;
				phase = COUNT_DELIMS;
			end
		endfunction

		// Advance the line state by one accepted transaction
		function void predict_char(byte_t c, logic line_end);
			res_t r;
			bit   d;
			bit   hit;
			bit   before_ok;
			int   n;
			if (line_end) begin
				r = '{arg_char: 8'h00, arg_done: 1'b1, found: arg_nonempty};
				expected_args.push_back(r);
				clear_line();
				return;
			end
			for (int k = 8; k > 0; k--) recent[k] = recent[k-1];
			recent[0] = c;
			if (chars_seen < 4'd9) chars_seen++;
			d = is_delim(c);
			case (phase)
				SEEK_LABEL: begin
					n = int'(label_length);
					if (n < 1) n = 1;
					if (n > 8) n = 8;
					hit = (chars_seen >= n);
					for (int k = 0; k < n; k++)
						if (recent[n-1-k] != label_text[8*k +: 8]) hit = 1'b0;
					if (hit) begin
						before_ok = (chars_seen == n) || is_delim(recent[n]);
						if (!before_ok) phase = LINE_FAILED;
						else if (d) take_anchor();
						else phase = CHECK_WORD_END;
					end
				end
				CHECK_WORD_END: begin
					if (d) take_anchor();
					else phase = LINE_FAILED;
				end
				COUNT_DELIMS: begin
					if (d) begin
						if (delims_seen == arg_index) phase = COPY_ARG;
						else delims_seen = delims_seen + 8'd1;
					end
				end
				COPY_ARG: begin
					if (d) begin
						phase = ARG_DONE;
					end else begin
						arg_nonempty = 1'b1;
						r = '{arg_char: c, arg_done: 1'b0, found: 1'b0};
						expected_args.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		// Count a failure, report only the first few
		function void flag(string msg);
			fails++;
			if (fails <= 10) $display("%s", msg);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_args.size() == 0) begin
				flag($sformatf("unexpected result: char %02h done %0b found %0b",
					got.arg_char, got.arg_done, got.found));
				return;
			end
			want = expected_args.pop_front();
			if (got.arg_char !== want.arg_char || got.arg_done !== want.arg_done ||
					got.found !== want.found)
				flag($sformatf("mismatch: expected char %02h done %0b found %0b, got %02h %0b %0b",
					want.arg_char, want.arg_done, want.found,
					got.arg_char, got.arg_done, got.found));
		endfunction

		function void check_drained();
			while (expected_args.size() != 0) begin
				flag($sformatf("missing result: char %02h done %0b found %0b",
					expected_args[0].arg_char, expected_args[0].arg_done,
					expected_args[0].found));
				void'(expected_args.pop_front());
			end
		endfunction
	endclass

endpackage

// ===== tb/tb_label_argument_extractor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Label argument extractor testbench
// Drives text lines into the extractor under several label, delimiter and
// argument settings, with random idling on both channels, and checks every
// returned argument character and final flag against the scoreboard.
// ----------------------------------------------------------------------------
module tb_label_argument_extractor;
	import lae_pkg::*;
	import lae_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 150;
	localparam int HOLD_CYCLES    = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	lae_char_if line_if ();
	lae_res_if  res_if ();

	arg_scoreboard sb;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int items_sent     = 0;

	// configuration as seen by the line builder
	logic [63:0] cur_label;
	logic [63:0] cur_delims;
	int          label_n;
	int          delim_n;
	int          cur_arg;

	byte_t line_buf [$];

	label_argument_extractor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.line      (line_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Drive result ready: long hold-off on request, else random stalls
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check results, note accepted inputs, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready)
				sb.check_result('{arg_char: res_if.arg_char, arg_done: res_if.arg_done,
					found: res_if.found});
			if (line_if.valid && line_if.ready)
				sb.predict_char(line_if.in_char, line_if.line_end);
			if ((res_if.valid && res_if.ready) || (line_if.valid && line_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Offer one transaction, idling first at random; returns on a falling edge
	task automatic send_item(input byte_t c, input logic le);
		int gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			line_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		line_if.valid    <= 1'b1;
		line_if.in_char  <= c;
		line_if.line_end <= le;
		@(posedge clk);
		while (!line_if.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Send the buffered characters, then the line end if asked
	task automatic send_line(input bit with_end);
		foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
		if (with_end) send_item(byte_t'($urandom_range(255)), 1'b1);
		line_buf.delete();
	endtask

	// Hold the sender until every expected result has come, then settle
	task automatic drain();
		line_if.valid <= 1'b0;
		while (sb.expected_args.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [63:0] lt, input logic [3:0] ll,
			input logic [63:0] ds, input logic [3:0] dc, input logic [7:0] ai);
		put_reg(REG_LABEL_TEXT, lt);
		put_reg(REG_LABEL_LENGTH, {60'd0, ll});
		put_reg(REG_DELIMITER_SET, ds);
		put_reg(REG_DELIMITER_COUNT, {60'd0, dc});
		put_reg(REG_ARG_INDEX, {56'd0, ai});
		cfg_we <= 1'b0;
		cur_label  = lt;
		cur_delims = ds;
		label_n    = (ll == 4'd0) ? 1 : (ll > 4'd8) ? 8 : int'(ll);
		delim_n    = (dc > 4'd8) ? 8 : int'(dc);
		cur_arg    = int'(ai);
	endtask

	function automatic byte_t pick_delim();
		int k;
		if (delim_n == 0) return byte_t'($urandom_range(255));
		k = $urandom_range(delim_n - 1);
		return cur_delims[8*k +: 8];
	endfunction

	// Text character biased toward label bytes and delimiters
	function automatic byte_t pick_text();
		int k;
		case ($urandom_range(9))
			0, 1: begin
				k = $urandom_range(label_n - 1);
				return cur_label[8*k +: 8];
			end
			2: return pick_delim();
			default: return byte_t'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_text(string s);
		foreach (s[i]) line_buf.push_back(byte_t'(s[i]));
	endfunction

	// Build a labeled line; a broken one may miss the word start, a delimiter or an argument
	function automatic void build_line(bit broken);
		int nargs;
		if ($urandom_range(1)) begin
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 4)) line_buf.push_back(pick_text());
				line_buf.push_back(pick_delim());
			end
		end
		if (broken && $urandom_range(2) == 0) line_buf.push_back(pick_text());
		for (int k = 0; k < label_n; k++) line_buf.push_back(cur_label[8*k +: 8]);
		if (!(broken && $urandom_range(1))) line_buf.push_back(pick_delim());
		nargs = broken ? $urandom_range(0, cur_arg) : cur_arg + $urandom_range(0, 2);
		for (int j = 0; j <= nargs; j++) begin
			repeat ($urandom_range(0, 3)) line_buf.push_back(pick_text());
			if (j < nargs || $urandom_range(1)) line_buf.push_back(pick_delim());
		end
	endfunction

	initial begin
		int         start;
		bit         held;
		bit         paused;
		logic [3:0] ll;
		logic [3:0] dc;
		logic [7:0] ai;
		logic [63:0] lt;
		logic [63:0] ds;

		sb = new();
		arst_n           = 1'b0;
		line_if.valid    = 1'b0;
		line_if.in_char  = '0;
		line_if.line_end = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		cur_label  = '0;
		cur_delims = '0;
		label_n    = 1;
		delim_n    = 1;
		cur_arg    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: label and delimiter are both byte zero
		line_buf.push_back(8'h00);
		line_buf.push_back(8'h41);
		send_line(1'b1);
		drain();

		// Directed lines with label KEY and delimiters = , newline
		apply_config(64'h0000_0000_0059_454B, 4'd3, 64'h0000_0000_000A_2C3D, 4'd3, 8'd0);
		push_text("KEY=ab");
		send_line(1'b1);
		// first occurrence not at a word start: not found
		push_text("xKEY");
		send_line(1'b1);
		// line end before the anchor
		push_text("KEY");
		send_line(1'b1);
		// zero character, then ignore the rest after the argument ends
		push_text(",KEY=a");
		line_buf.push_back(8'h00);
		push_text(",b");
		send_line(1'b1);
		drain();

		// Random phases over settings and idling modes
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin ll = 4'd1;  dc = 4'd8;  ai = 8'd0; end
				1: begin ll = 4'd8;  dc = 4'd1;  ai = 8'd3; end
				2: begin ll = 4'd0;  dc = 4'd0;  ai = 8'd1; end
				3: begin ll = 4'd15; dc = 4'd15; ai = 8'd2; end
				default: begin
					ll = 4'($urandom_range(15));
					dc = 4'($urandom_range(15));
					ai = 8'($urandom_range(3));
				end
			endcase
			lt = {$urandom, $urandom};
			ds = {$urandom, $urandom};
			if (p == 1) lt = '1;
			if (p == 2) lt = '0;
			if (p == 3) ds = '1;
			if (p == 4) ds = '0;
			apply_config(lt, ll, ds, dc, ai);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			start  = items_sent;
			held   = 1'b0;
			paused = 1'b0;
			while (items_sent - start < PHASE_ITEMS) begin
				case ($urandom_range(7))
					0: repeat ($urandom_range(0, 12)) line_buf.push_back(pick_text());
					1: build_line(1'b1);
					default: build_line(1'b0);
				endcase
				send_line(1'b1);
				// fill the block while the result side holds off
				if (p == 0 && !held && items_sent - start >= 60) begin
					hold_reqs++;
					held = 1'b1;
				end
				// let every result drain before going on
				if (p == 1 && !paused && items_sent - start >= 60) begin
					drain();
					paused = 1'b1;
				end
			end
			drain();
		end

		// Long delimiter runs: highest argument index, then a mid-line
		// index change that makes the delimiter counter wrap
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		apply_config(64'h6261, 4'd2, 64'h2C, 4'd1, 8'd255);
		push_text("ab");
		repeat (256) line_buf.push_back(8'h2C);
		push_text("xy");
		send_line(1'b1);
		drain();
		put_reg(REG_ARG_INDEX, 64'd200);
		cfg_we <= 1'b0;
		push_text("ab");
		repeat (100) line_buf.push_back(8'h2C);
		send_line(1'b0);
		drain();
		put_reg(REG_ARG_INDEX, 64'd50);
		cfg_we <= 1'b0;
		repeat (206) line_buf.push_back(8'h2C);
		push_text("xyz");
		send_line(1'b1);

		drain();
		sb.check_drained();
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
